>>> src/assert_macros.svh
// Concurrent assertion helpers. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DLRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define DLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/dlre_pkg.sv
package dlre_pkg;

	localparam int unsigned DEPTH    = 1024;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);
	localparam int unsigned HELD_W   = $clog2(DEPTH + 1);
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 11;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [HELD_W-1:0] held_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_APPEND  = 3'd1,
		CMD_REVERSE = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_ERROR = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// One access slot of the ring store per cycle: a write or a read
	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	function automatic addr_t ring_next(input addr_t i);
		return (i == addr_t'(DEPTH - 1)) ? '0 : i + addr_t'(1);
	endfunction

	function automatic addr_t ring_prev(input addr_t i);
		return (i == '0) ? addr_t'(DEPTH - 1) : i - addr_t'(1);
	endfunction

endpackage

>>> src/dlre_cmd_if.sv
interface dlre_cmd_if import dlre_pkg::*;;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [DATA_W-1:0]   element_value;

	modport source (output valid, output command, output element_value, input ready);
	modport sink   (input valid, input command, input element_value, output ready);
endinterface

>>> src/dlre_res_if.sv
interface dlre_res_if import dlre_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   read_value;
	logic                last;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, output status, output read_value, output last,
		output count, input ready);
	modport sink   (input valid, input status, input read_value, input last,
		input count, output ready);
endinterface

>>> src/dlre_ram.sv
module dlre_ram #(
	parameter int unsigned Depth = 1024,
	parameter int unsigned Width = 16,
	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/dlre_ctrl.sv
`include "assert_macros.svh"

module dlre_ctrl import dlre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	dlre_cmd_if.sink   cmd,
	dlre_res_if.source res,
	output mem_req_t mem_req,
	input  data_t    mem_rdata
);

	// queue state
	addr_t front_q, back_q;
	held_t held_q;
	logic  rev_q, err_q;

	// stage 1: waits for store read data
	logic               s1_valid_q;
	status_t            status_s1;
	logic               last_s1;
	logic               read_s1;
	logic [COUNT_W-1:0] count_s1;

	// output register
	logic               out_valid_q;
	status_t            out_status_q;
	data_t              out_value_q;
	logic               out_last_q;
	logic [COUNT_W-1:0] out_count_q;

	logic    out_free, s1_adv, accept;
	cmd_t    cmd_code;
	addr_t   front_n, back_n, rm_addr;
	held_t   held_n;
	logic    rev_n, err_n;
	status_t status_n;
	logic    last_n, read_n;
	logic    we_n, re_n;
	addr_t   waddr_n;

	assign out_free  = !out_valid_q || res.ready;
	assign s1_adv    = s1_valid_q && out_free;
	assign cmd.ready = !s1_valid_q || out_free;
	assign accept    = cmd.valid && cmd.ready;
	assign cmd_code  = cmd_t'(cmd.command);

	// logical front is the physical back slot when reversed
	assign rm_addr = rev_q ? ring_prev(back_q) : front_q;

	always_comb begin
		front_n  = front_q;
		back_n   = back_q;
		held_n   = held_q;
		rev_n    = rev_q;
		err_n    = err_q;
		status_n = ST_OK;
		last_n   = 1'b0;
		read_n   = 1'b0;
		we_n     = 1'b0;
		re_n     = 1'b0;
		waddr_n  = back_q;
		if (cmd_code == CMD_CLEAR) begin
			front_n = '0;
			back_n  = '0;
			held_n  = '0;
			rev_n   = 1'b0;
			err_n   = 1'b0;
		end else if (err_q) begin
			status_n = ST_ERROR;
		end else begin
			case (cmd_code)
				CMD_APPEND: begin
					if (held_q == held_t'(DEPTH)) begin
						status_n = ST_FULL;
					end else begin
						we_n = 1'b1;
						if (!rev_q) begin
							waddr_n = back_q;
							back_n  = ring_next(back_q);
						end else begin
							front_n = ring_prev(front_q);
							waddr_n = ring_prev(front_q);
						end
						held_n = held_q + held_t'(1);
					end
				end
				CMD_REVERSE: begin
					rev_n = !rev_q;
				end
				CMD_DELETE, CMD_READ: begin
					if (held_q == '0) begin
						if (cmd_code == CMD_DELETE) begin
							err_n    = 1'b1;
							status_n = ST_ERROR;
						end else begin
							status_n = ST_EMPTY;
						end
					end else begin
						if (!rev_q) begin
							front_n = ring_next(front_q);
						end else begin
							back_n = rm_addr;
						end
						held_n = held_q - held_t'(1);
						if (cmd_code == CMD_READ) begin
							re_n   = 1'b1;
							read_n = 1'b1;
							last_n = (held_q == held_t'(1));
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		mem_req.we    = accept && we_n;
		mem_req.waddr = waddr_n;
		mem_req.wdata = cmd.element_value;
		mem_req.re    = accept && re_n;
		mem_req.raddr = rm_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			held_q  <= '0;
			rev_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			front_q <= front_n;
			back_q  <= back_n;
			held_q  <= held_n;
			rev_q   <= rev_n;
			err_q   <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_n;
			last_s1   <= last_n;
			read_s1   <= read_n;
			count_s1  <= COUNT_W'(held_n);
		end
		if (s1_adv) begin
			out_status_q <= status_s1;
			out_value_q  <= read_s1 ? mem_rdata : '0;
			out_last_q   <= last_s1;
			out_count_q  <= count_s1;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.status     = out_status_q;
	assign res.read_value = out_value_q;
	assign res.last       = out_last_q;
	assign res.count      = out_count_q;

	`DLRE_ASSERT(a_held_range, held_q <= held_t'(DEPTH), "held count beyond depth")
	`DLRE_ASSERT(a_empty_ptrs, (held_q != '0) || (front_q == back_q), "empty ring with split pointers")
	`DLRE_ASSERT_NEXT(a_clear, accept && (cmd_code == CMD_CLEAR), (held_q == '0) && !err_q && !rev_q, "clear left state behind")
	`DLRE_ASSERT_NEXT(a_err_sticky, err_q && !(accept && (cmd_code == CMD_CLEAR)), err_q, "error flag dropped without clear")
	`DLRE_ASSERT(a_one_access, !(mem_req.we && mem_req.re), "store written and read in one cycle")

endmodule

>>> src/deque_lazy_reverse_engine.sv
// Channel  Dir  Payload                                  Handshake
// cmd      in   command, element_value                   valid / ready
// res      out  status, read_value, last, count          valid / ready
//
// One request per cycle unless res stalls; results pass stage 1, then the output register.
// Stage 1 waits on the registered read of the ring store (one write or one read per cycle).
// An output register follows; cmd.ready drops only while both are full and res.ready is low.
// arst_n clears pointers, count, reverse and error flags; ring store contents stay undefined.
module deque_lazy_reverse_engine import dlre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dlre_cmd_if.sink   cmd,
	dlre_res_if.source res
);

	mem_req_t mem_req;
	data_t    mem_rdata;

	dlre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	dlre_ram #(
		.Depth (DEPTH),
		.Width (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule
